FILE: design/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
package fbpa_pkg;

    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int ADDR_W = 32;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY       = 3'd1;
    localparam logic [2:0] ST_MISMATCH    = 3'd2;
    localparam logic [2:0] ST_NONE_IN_USE = 3'd3;
    localparam logic [2:0] ST_NULL        = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX   = 3'd5;

    localparam logic [1:0] REG_BLOCK_COUNT  = 2'd0;
    localparam logic [1:0] REG_BLOCK_BYTES  = 2'd1;
    localparam logic [1:0] REG_ALIGN_BYTES  = 2'd2;
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [15:0]      request_bytes;
        logic [12:0]      request_align;
        logic [IDX_W-1:0] block_index;
        logic             handle_null;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]  block_count;
        logic [15:0]       block_bytes;
        logic [12:0]       align_bytes;
        logic [ADDR_W-1:0] base_address;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [IDX_W-1:0]  granted_index;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  blocks_in_use;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] freed_depth;
        logic [CNT_W-1:0] fresh_mark;
        logic [CNT_W-1:0] in_use;
    } pool_state_t;

    typedef struct packed {
        logic             push;
        logic [IDX_W-1:0] push_idx;
        logic [CNT_W-1:0] wr_depth;
        logic [CNT_W-1:0] rd_depth;
    } stk_req_t;

endpackage

FILE: design/fbpa_stack.sv
// Free-list stack memory with registered read and write-through bypass of the top entry.
module fbpa_stack #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbpa_pkg::stk_req_t            req,
    output logic [fbpa_pkg::IDX_W-1:0]    top
);
    import fbpa_pkg::*;

    localparam int AW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int EXT_W = (AW > CNT_W) ? AW : CNT_W;

    logic [IDX_W-1:0] mem [NUM_BLOCKS];
    logic [IDX_W-1:0] rd_data_reg;
    logic             byp_valid_reg;
    logic             byp_valid_next;
    logic [IDX_W-1:0] byp_idx_reg;
    logic [EXT_W-1:0] wr_ext;
    logic [EXT_W-1:0] rd_ext;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign wr_ext  = EXT_W'(req.wr_depth);
    assign rd_ext  = EXT_W'(req.rd_depth);
    assign wr_addr = wr_ext[AW-1:0];
    assign rd_addr = rd_ext[AW-1:0];

    // a push always lands on the address being read this cycle, so it is forwarded
    assign byp_valid_next = req.push;

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[wr_addr] <= req.push_idx;
        end
        rd_data_reg <= mem[rd_addr];
        byp_idx_reg <= req.push_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= byp_valid_next;
        end
    end

    assign top = byp_valid_reg ? byp_idx_reg : rd_data_reg;

endmodule

FILE: design/fbpa_core.sv
// Pool state registers and the per-request allocate/free/clear decision.
module fbpa_core #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        exec,
    input  fbpa_pkg::item_t             item,
    input  fbpa_pkg::cfg_t              cfg,
    input  logic [fbpa_pkg::IDX_W-1:0]  top,
    output fbpa_pkg::result_t           result,
    output fbpa_pkg::stk_req_t          stk_req,
    output fbpa_pkg::pool_state_t       state
);
    import fbpa_pkg::*;

    localparam int CAP = (NUM_BLOCKS > 2047) ? 2047 : NUM_BLOCKS;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    pool_state_t      state_reg;
    pool_state_t      state_next;
    logic [CNT_W-1:0] usable;
    logic             size_match;
    logic             granted;
    logic             push;
    logic [IDX_W-1:0] g_idx;
    logic [2:0]       status;
    logic [16:0]      pitch;
    logic [26:0]      offset;

    assign usable     = (cfg.block_count > CAP_CNT) ? CAP_CNT : cfg.block_count;
    assign size_match = (item.request_bytes == cfg.block_bytes) &&
                        (item.request_align == cfg.align_bytes);

    always_comb
    begin
        state_next = state_reg;
        status     = ST_OK;
        granted    = 1'b0;
        push       = 1'b0;
        g_idx      = '0;
        case (item.op)
            OP_ALLOC:
            begin
                if (!size_match)
                begin
                    status = ST_MISMATCH;
                end
                else if (state_reg.freed_depth != '0)
                begin
                    granted                = 1'b1;
                    g_idx                  = top;
                    state_next.freed_depth = state_reg.freed_depth - 1'b1;
                    state_next.in_use      = state_reg.in_use + 1'b1;
                end
                else if (state_reg.fresh_mark < usable)
                begin
                    granted               = 1'b1;
                    g_idx                 = state_reg.fresh_mark[IDX_W-1:0];
                    state_next.fresh_mark = state_reg.fresh_mark + 1'b1;
                    state_next.in_use     = state_reg.in_use + 1'b1;
                end
                else
                begin
                    status = ST_EMPTY;
                end
            end
            OP_FREE:
            begin
                if (item.handle_null)
                begin
                    status = ST_NULL;
                end
                else if (state_reg.in_use == '0)
                begin
                    status = ST_NONE_IN_USE;
                end
                else if ({1'b0, item.block_index} >= state_reg.fresh_mark)
                begin
                    status = ST_BAD_INDEX;
                end
                else
                begin
                    push                   = 1'b1;
                    state_next.freed_depth = state_reg.freed_depth + 1'b1;
                    state_next.in_use      = state_reg.in_use - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                state_next = '0;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    assign pitch  = {1'b0, cfg.block_bytes} + 17'(cfg.align_bytes);
    assign offset = 27'(g_idx) * 27'(pitch);

    assign result.status          = status;
    assign result.granted_index   = g_idx;
    assign result.granted_address = granted ? (cfg.base_address + 32'(offset)) : '0;
    assign result.blocks_in_use   = state_next.in_use;

    // read address follows the depth that the next request will see
    assign stk_req.push     = exec && push;
    assign stk_req.push_idx = item.block_index;
    assign stk_req.wr_depth = state_reg.freed_depth;
    assign stk_req.rd_depth = (exec ? state_next.freed_depth : state_reg.freed_depth) - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (exec)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

FILE: design/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: channels, config registers, pipeline.
//
// Requests enter on the s_ stream: s_tuser carries the op (allocate, free,
// clear) and s_tdata the request fields. Each request yields one result on
// the m_ stream: m_tuser carries the status and m_tdata the granted block
// index, its byte address and the in-use count after the request.
// Registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. Write them only while no request is in flight.
// A request passes an input register and a result register: the result is
// loaded into the result register from the input register once the result
// register is empty or its result is being taken. One request per cycle is
// sustained while m_tready stays high; the free-list stack top is kept ready
// by a registered memory read plus a one-entry forward of the last pushed block.
// A stall on m_tready holds the result; the input register keeps taking a
// request while the held result is being taken in the same cycle.
// Reset empties the pool (nothing handed out, free list empty) and loads the
// register defaults; the stack memory needs no clearing.
module fixed_block_pool_allocator #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_bytes, request_align, block_index, handle_null
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // granted_index, granted_address, blocks_in_use, zero pad
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fbpa_pkg::*;

    cfg_t        cfg_reg;
    item_t       in_item_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        advance;
    result_t     result;
    stk_req_t    stk_req;
    pool_state_t state;
    logic [IDX_W-1:0] top;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_count  <= 11'd1024;
            cfg_reg.block_bytes  <= 16'd64;
            cfg_reg.align_bytes  <= 13'd8;
            cfg_reg.base_address <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BLOCK_COUNT:  cfg_reg.block_count  <= cfg_data[CNT_W-1:0];
                REG_BLOCK_BYTES:  cfg_reg.block_bytes  <= cfg_data[15:0];
                REG_ALIGN_BYTES:  cfg_reg.align_bytes  <= cfg_data[12:0];
                REG_BASE_ADDRESS: cfg_reg.base_address <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.op            <= s_tuser;
            in_item_reg.request_bytes <= s_tdata[15:0];
            in_item_reg.request_align <= s_tdata[28:16];
            in_item_reg.block_index   <= s_tdata[38:29];
            in_item_reg.handle_null   <= s_tdata[39];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    fbpa_core #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .exec    (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .top     (top),
        .result  (result),
        .stk_req (stk_req),
        .state   (state)
    );

    fbpa_stack #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stk_req),
        .top   (top)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.blocks_in_use, out_reg.granted_address,
                       out_reg.granted_index};

    // every block handed out or waiting on the free list came from below fresh_mark
    a_pool_accounting: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, state.freed_depth} + {1'b0, state.in_use}) <= {1'b0, state.fresh_mark})
        else $error("pool accounting exceeds fresh mark");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.op == OP_CLEAR) |=>
        (state.freed_depth == '0 && state.fresh_mark == '0 && state.in_use == '0))
        else $error("clear did not empty the pool");

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[41:0] == '0))
        else $error("failed request carries a granted block");

endmodule

FILE: dv/fixed_block_pool_allocator_test.sv
// Self-checking testbench for the fixed block pool allocator: streams and register writes.
module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int POOL_BLOCKS = 1024;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 30;
    localparam int FILL_ITEMS  = 1030;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // request_bytes, request_align, block_index, handle_null
    logic [1:0]  s_tuser = '0;    // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // granted_index, granted_address, blocks_in_use, zero pad
    logic [2:0]  m_tuser;         // status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    fixed_block_pool_allocator #(
        .NUM_BLOCKS(POOL_BLOCKS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // register shadow and pool state as the block should hold them
    logic [CNT_W-1:0]  cur_count = 11'd1024;
    logic [15:0]       cur_bytes = 16'd64;
    logic [12:0]       cur_align = 13'd8;
    logic [ADDR_W-1:0] cur_base = '0;
    logic [IDX_W-1:0]  freed_stack [POOL_BLOCKS];
    logic [CNT_W-1:0]  freed_depth = '0;
    logic [CNT_W-1:0]  fresh_mark = '0;
    logic [CNT_W-1:0]  in_use = '0;

    item_t   request_queue [$];
    result_t expected_results [$];
    item_t   drv_item;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    // stimulus-side view of the pool, enough to aim frees at handed-out blocks
    logic [15:0]      plan_bytes = 16'd64;
    logic [12:0]      plan_align = 13'd8;
    int               plan_usable = POOL_BLOCKS;
    int               plan_live = 0;
    int               plan_hi = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic pool_grant(input item_t it, output result_t res);
        logic [CNT_W-1:0] usable;
        logic             granted;
        usable = cur_count;
        if (usable > POOL_BLOCKS)
            usable = CNT_W'(POOL_BLOCKS);
        res = '0;
        res.status = ST_OK;
        granted = 1'b0;
        case (it.op)
            OP_ALLOC:
            begin
                if (it.request_bytes != cur_bytes || it.request_align != cur_align)
                    res.status = ST_MISMATCH;
                else if (freed_depth != 0)
                begin
                    freed_depth = freed_depth - 1'b1;
                    res.granted_index = freed_stack[freed_depth[IDX_W-1:0]];
                    granted = 1'b1;
                end
                else if (fresh_mark < usable)
                begin
                    res.granted_index = fresh_mark[IDX_W-1:0];
                    fresh_mark = fresh_mark + 1'b1;
                    granted = 1'b1;
                end
                else
                    res.status = ST_EMPTY;
                if (granted)
                begin
                    in_use = in_use + 1'b1;
                    res.granted_address = cur_base + 32'(res.granted_index) *
                                          (32'(cur_bytes) + 32'(cur_align));
                end
            end
            OP_FREE:
            begin
                if (it.handle_null)
                    res.status = ST_NULL;
                else if (in_use == 0)
                    res.status = ST_NONE_IN_USE;
                else if ({1'b0, it.block_index} >= fresh_mark)
                    res.status = ST_BAD_INDEX;
                else
                begin
                    // double frees are pushed again on purpose
                    freed_stack[freed_depth[IDX_W-1:0]] = it.block_index;
                    freed_depth = freed_depth + 1'b1;
                    in_use = in_use - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                freed_depth = '0;
                fresh_mark = '0;
                in_use = '0;
            end
            default:
            begin
            end
        endcase
        res.blocks_in_use = in_use;
    endtask

    task automatic note_error(input string field, input logic [31:0] got,
                              input logic [31:0] want);
        if (error_count < 50)
            $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLOCK_COUNT:  cur_count <= cfg_data[CNT_W-1:0];
                REG_BLOCK_BYTES:  cur_bytes <= cfg_data[15:0];
                REG_ALIGN_BYTES:  cur_align <= cfg_data[12:0];
                REG_BASE_ADDRESS: cur_base <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // request driver: predicts on every accepted request, then offers the next one
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pool_grant(drv_item, want);
                expected_results.push_back(want);
            end
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    drv_item = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {drv_item.handle_null, drv_item.block_index,
                                drv_item.request_align, drv_item.request_bytes};
                    s_tuser <= drv_item.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.granted_index = m_tdata[9:0];
                got.granted_address = m_tdata[41:10];
                got.blocks_in_use = m_tdata[52:42];
                if (expected_results.size() == 0)
                    note_error("unexpected result, status", 32'(got.status), 32'hFFFFFFFF);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        note_error("status", 32'(got.status), 32'(want.status));
                    if (got.granted_index !== want.granted_index)
                        note_error("granted_index", 32'(got.granted_index),
                                   32'(want.granted_index));
                    if (got.granted_address !== want.granted_address)
                        note_error("granted_address", got.granted_address,
                                   want.granted_address);
                    if (got.blocks_in_use !== want.blocks_in_use)
                        note_error("blocks_in_use", 32'(got.blocks_in_use),
                                   32'(want.blocks_in_use));
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void queue_item(input item_t it);
        case (it.op)
            OP_ALLOC:
            begin
                if (it.request_bytes == plan_bytes && it.request_align == plan_align)
                begin
                    if (plan_hi > plan_live)
                        plan_live++;
                    else if (plan_hi < plan_usable)
                    begin
                        plan_hi++;
                        plan_live++;
                    end
                end
            end
            OP_FREE:
            begin
                if (!it.handle_null && plan_live > 0 && int'(it.block_index) < plan_hi)
                    plan_live--;
            end
            OP_CLEAR:
            begin
                plan_live = 0;
                plan_hi = 0;
            end
            default:
            begin
            end
        endcase
        request_queue.push_back(it);
    endfunction

    function automatic item_t make_item(input logic [1:0] op, input logic [15:0] nbytes,
                                        input logic [12:0] nalign, input logic [9:0] idx,
                                        input logic nul);
        item_t it;
        it.op = op;
        it.request_bytes = nbytes;
        it.request_align = nalign;
        it.block_index = idx;
        it.handle_null = nul;
        return it;
    endfunction

    function automatic item_t good_alloc();
        return make_item(OP_ALLOC, plan_bytes, plan_align, 10'($urandom), 1'($urandom));
    endfunction

    function automatic item_t random_request(input int alloc_pct);
        item_t it;
        int    roll;
        int    pick;
        it = make_item(OP_FREE, 16'($urandom), 13'($urandom_range(8191)), 10'($urandom), 1'b0);
        roll = $urandom_range(99);
        if (roll < 2)
            it.op = OP_CLEAR;
        else if (roll < 4)
        begin
            it.op = OP_UNUSED;
            it.handle_null = 1'($urandom);
        end
        else if (roll < 10)
        begin
            // size or alignment most likely off
            it.op = OP_ALLOC;
            it.handle_null = 1'($urandom);
        end
        else if (roll < 10 + alloc_pct)
            it = good_alloc();
        else
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                it.handle_null = 1'b1;
            else if (pick >= 16 && plan_hi > 0)
                it.block_index = 10'($urandom_range(plan_hi - 1));
        end
        return it;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct = 73;
                snk_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct = 0;
                snk_stall_pct = 73;
            end
            default:
            begin
                src_idle_pct = 27;
                snk_stall_pct = 27;
            end
        endcase
    endtask

    initial
    begin
        logic [CNT_W-1:0]  cnt;
        logic [31:0]       base;
        logic [31:0]       cnt_word;
        int                alloc_pct;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_idle(3);

        // directed, register defaults: 64 byte blocks, 8 byte padding
        queue_item(make_item(OP_FREE, 16'd0, 13'd0, 10'd0, 1'b0));        // nothing in use
        queue_item(make_item(OP_FREE, 16'd0, 13'd0, 10'd0, 1'b1));        // null wins
        queue_item(make_item(OP_ALLOC, 16'd63, 13'd8, 10'd0, 1'b0));
        queue_item(make_item(OP_ALLOC, 16'd64, 13'd0, 10'd0, 1'b0));
        queue_item(make_item(OP_ALLOC, 16'hFFFF, 13'h1FFF, 10'h3FF, 1'b1));
        repeat (3) queue_item(make_item(OP_ALLOC, 16'd64, 13'd8, 10'd0, 1'b0));
        queue_item(make_item(OP_FREE, 16'hFFFF, 13'h1FFF, 10'h3FF, 1'b0)); // never handed out
        queue_item(make_item(OP_FREE, 16'd0, 13'd0, 10'd3, 1'b0));
        queue_item(make_item(OP_FREE, 16'd0, 13'd0, 10'd1, 1'b0));
        queue_item(make_item(OP_FREE, 16'd0, 13'd0, 10'd0, 1'b0));
        repeat (2) queue_item(make_item(OP_ALLOC, 16'd64, 13'd8, 10'd0, 1'b0)); // LIFO order
        repeat (2) queue_item(make_item(OP_FREE, 16'd0, 13'd0, 10'd2, 1'b0));   // double free
        repeat (2) queue_item(make_item(OP_ALLOC, 16'd64, 13'd8, 10'd0, 1'b0));
        queue_item(make_item(OP_UNUSED, 16'hFFFF, 13'h1FFF, 10'h3FF, 1'b1));
        queue_item(make_item(OP_FREE, 16'd0, 13'd0, 10'h3FF, 1'b1));
        queue_item(make_item(OP_CLEAR, 16'd0, 13'd0, 10'd0, 1'b0));
        queue_item(make_item(OP_ALLOC, 16'd64, 13'd8, 10'd0, 1'b0));
        wait_idle();

        // one-block pool: exhaustion, and mismatch checked ahead of it
        write_reg(REG_BLOCK_COUNT, 32'd1);
        plan_usable = 1;
        @(negedge clk);
        queue_item(make_item(OP_ALLOC, 16'd64, 13'd8, 10'd0, 1'b0));
        queue_item(make_item(OP_ALLOC, 16'd65, 13'd8, 10'd0, 1'b0));
        queue_item(make_item(OP_FREE, 16'd0, 13'd0, 10'd0, 1'b0));
        queue_item(make_item(OP_ALLOC, 16'd64, 13'd8, 10'd0, 1'b0));

        for (int p = 0; p < 12; p++)
        begin
            wait_idle();
            case (p)
                0: cnt = 11'd1;
                1: cnt = 11'd2;
                2: cnt = 11'd3;
                3: cnt = 11'd0;
                4: cnt = 11'd5;
                5: cnt = 11'd8;
                6: cnt = 11'd2047;
                7: cnt = 11'd16;
                8: cnt = 11'd1024;
                9: cnt = 11'd4;
                10: cnt = 11'd7;
                default: cnt = 11'd33;
            endcase
            plan_bytes = (p == 0) ? 16'hFFFF : (p == 1) ? 16'd1 : (p == 2) ? 16'd0 :
                         16'($urandom);
            plan_align = (p == 0) ? 13'h1FFF : (p == 1) ? 13'd1 : (p == 2) ? 13'd0 :
                         (p == 3) ? 13'd4096 : 13'($urandom);
            base = (p == 0) ? 32'hFFFFFFFF : (p == 1) ? 32'd0 : $urandom;
            // upper bits of the count word are junk now and then
            cnt_word = (p % 3 == 0) ? (($urandom & ~32'h7FF) | 32'(cnt)) : 32'(cnt);
            write_reg(REG_BLOCK_COUNT, cnt_word);
            write_reg(REG_BLOCK_BYTES, 32'(plan_bytes));
            write_reg(REG_ALIGN_BYTES, 32'(plan_align));
            write_reg(REG_BASE_ADDRESS, base);
            plan_usable = (cnt > POOL_BLOCKS) ? POOL_BLOCKS : int'(cnt);
            alloc_pct = 30 + $urandom_range(40);
            @(negedge clk);
            set_idle(p % 4);
            if (p == 6)
            begin
                // fill the whole pool past its clamp at the full block count
                queue_item(make_item(OP_CLEAR, 16'd0, 13'd0, 10'd0, 1'b0));
                repeat (FILL_ITEMS) queue_item(good_alloc());
            end
            repeat (PHASE_ITEMS) queue_item(random_request(alloc_pct));
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
